/* src/sha_pkg.sv */
`timescale 1ns / 1ps

package sha_pkg;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef logic [31:0] word_t;

  // start/done between sequencer and round engine
  typedef struct packed {
    logic start;
  } core_req_t;

  typedef struct packed {
    logic done;
  } core_rsp_t;

  function automatic word_t rotr(input word_t x, input int unsigned s);
    rotr = (x >> s) | (x << (32 - s));
  endfunction

endpackage

/* src/sha256_message_hasher.sv */
`timescale 1ns / 1ps

// SHA-256 hasher: a data beat (action=0) goes into the block buffer, except the 64th byte
// of a block, which starts a compression (64 rounds, one per cycle, plus load and fold)
// in the shared round engine. A finish beat pads byte by byte
// (one pad byte per cycle), runs one or two compressions and then emits eight
// digest beats, h0 first; the state then returns to the initial hash values.
module sha256_message_hasher import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic        action,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_COMP = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;

  logic [2:0]   state;
  logic [511:0] buffer;
  logic [511:0] block_next;
  logic [5:0]   fill;
  logic [63:0]  byte_count;
  logic [63:0]  bits;
  logic         finishing;
  logic         len_done;
  logic         spill;
  logic         core_rst;
  core_req_t    req;
  core_rsp_t    rsp;
  logic [255:0] chain;

  sha_core u_core (
    .clk(clk), .rst(core_rst), .req(req), .block(block_next), .rsp(rsp), .chain(chain)
  );

  logic [7:0] pad_byte;
  always_comb begin
    if (spill) pad_byte = 8'h00;
    else if (fill >= LEN_POS) pad_byte = bits[8*(63 - fill) +: 8];
    else pad_byte = 8'h00;
  end

  assign ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign digest_word = chain[255 - 32*word_index -: 32];
  assign last_word = (word_index == 3'd7);

  logic [7:0] put_val;
  logic       put_en;
  always_comb begin
    put_en  = 1'b0;
    put_val = data_byte;
    req.start = 1'b0;
    if (state == S_IDLE && valid) begin
      put_en = 1'b1;
      if (action) put_val = PAD_BYTE;
    end
    if (state == S_PAD) begin
      put_en = 1'b1;
      put_val = pad_byte;
    end
    if (put_en && fill == 6'd63) req.start = 1'b1;
  end
  assign core_rst = rst || (state == S_CLR);

  // bytes shift in at the bottom; the engine loads the block including this cycle's byte
  assign block_next = {buffer[503:0], put_val};

  always_ff @(posedge clk) begin
    if (put_en) buffer <= block_next;
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      byte_count <= '0;
      word_index <= '0;
      finishing <= 1'b0;
      len_done <= 1'b0;
      spill <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (valid && !action) begin
            byte_count <= byte_count + 64'd1;
            fill <= fill + 6'd1;
            if (fill == 6'd63) state <= S_COMP;
          end else if (valid) begin
            // pad byte shifts in through put_val
            bits <= {byte_count[60:0], 3'b000};
            fill <= fill + 6'd1;
            finishing <= 1'b1;
            len_done <= 1'b0;
            spill <= (fill >= LEN_POS);
            state <= (fill == 6'd63) ? S_COMP : S_PAD;
          end
        end
        S_PAD: begin
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin
            state <= S_COMP;
            len_done <= !spill;
          end
        end
        S_COMP: begin
          if (rsp.done) begin
            if (!finishing) state <= S_IDLE;
            else if (len_done) state <= S_OUT;
            else begin
              state <= S_PAD;
              spill <= 1'b0;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            word_index <= word_index + 3'd1;
            if (word_index == 3'd7) state <= S_CLR;
          end
        end
        S_CLR: begin
          state <= S_IDLE;
          fill <= '0;
          byte_count <= '0;
          finishing <= 1'b0;
          len_done <= 1'b0;
          spill <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // In S_PAD, zeros up to 55 and the length bytes at 56..63. If the pad byte
  // landed at 56 or later (spill), this block holds zeros only and the length
  // goes into the next one; len_done marks the block that carries the length.

  a_digest_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> finishing && len_done) else $error("digest without length block");
  a_idle_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> fill == 6'd0) else $error("buffer not empty at output");
  a_start_full: assert property (@(posedge clk) disable iff (rst)
    req.start |-> fill == 6'd63) else $error("compress on partial block");

endmodule

/* src/sha_core.sv */
`timescale 1ns / 1ps

// One round per cycle; the schedule is a 16-word shift line fed from the block words.
module sha_core import sha_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  core_req_t      req,
  input  logic [511:0]   block,
  output core_rsp_t      rsp,
  output logic [255:0]   chain
);

  word_t h [8];
  word_t v [8];
  word_t w [16];
  logic [5:0] round;
  logic       busy;
  logic       fold;

  word_t wr, w2, w15, s0, s1, t1, t2, e, a;

  always_comb begin
    w2  = w[14];
    w15 = w[1];
    s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    wr  = (round < 6'd16) ? w[round[3:0]] : (s1 + w[9] + s0 + w[0]);
    e   = v[4];
    a   = v[0];
    t1  = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
          ((e & v[5]) ^ (~e & v[6])) + ROUND_K[round] + wr;
    t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
          ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fold <= 1'b0;
      round <= '0;
      for (int i = 0; i < 8; i++) h[i] <= INIT_H[i];
    end else if (req.start) begin
      busy <= 1'b1;
      round <= '0;
      for (int i = 0; i < 16; i++) w[i] <= block[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) v[i] <= h[i];
    end else if (busy) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
      // from round 16 on the window slides and takes the new word at the top
      if (round >= 6'd16) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= wr;
      end
      round <= round + 6'd1;
      if (round == 6'd63) begin
        busy <= 1'b0;
        fold <= 1'b1;
      end
    end else if (fold) begin
      fold <= 1'b0;
      for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
    end else if (req == '0 && rsp.done == 1'b0) begin
      h <= h;
    end
  end

  assign rsp.done = fold;
  always_comb for (int i = 0; i < 8; i++) chain[255 - 32*i -: 32] = h[i];

  // reset of chain handled by top via reinit
endmodule

/* tb/sha256_message_hasher_tb.sv */
`timescale 1ns / 1ps

module sha256_message_hasher_tb;
  import sha_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  digest_beat_t digest_q[$];
  int          errors = 0;
  int          items_sent = 0;
  bit          hold_off = 1'b0;

  // hash state mirrored by the predictor
  logic [31:0] chain[8];
  logic [7:0]  blk[64];
  int          fill;
  logic [63:0] msg_bytes;

  sha256_message_hasher dut (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .action(action),
    .data_byte(data_byte), .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] ror(logic [31:0] x, int s);
    return (x >> s) | (x << (32 - s));
  endfunction

  task automatic hash_init();
    for (int i = 0; i < 8; i++) chain[i] = INIT_H[i];
    fill = 0;
    msg_bytes = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int j = 0; j < 16; j++)
      w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
    for (int j = 16; j < 64; j++) begin
      s0 = ror(w[j-15], 7) ^ ror(w[j-15], 18) ^ (w[j-15] >> 3);
      s1 = ror(w[j-2], 17) ^ ror(w[j-2], 19) ^ (w[j-2] >> 10);
      w[j] = s1 + w[j-7] + s0 + w[j-16];
    end
    {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                chain[4], chain[5], chain[6], chain[7]};
    for (int r = 0; r < 64; r++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[r] + w[r];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endtask

  task automatic push_byte(logic [7:0] v);
    blk[fill] = v;
    fill++;
    if (fill == 64) begin
      compress_block();
      fill = 0;
    end
  endtask

  // predict the effect of one accepted beat
  task automatic hash_beat(logic act, logic [7:0] v);
    logic [63:0] bits;
    digest_beat_t d;
    if (!act) begin
      msg_bytes++;
      push_byte(v);
    end else begin
      bits = msg_bytes << 3;
      push_byte(PAD_BYTE);
      while (fill != LEN_POS) push_byte(8'h00);
      for (int i = 7; i >= 0; i--) push_byte(bits[8*i +: 8]);
      for (int i = 0; i < 8; i++) begin
        d.word = chain[i];
        d.idx  = i[2:0];
        d.last = (i == 7);
        digest_q.push_back(d);
      end
      hash_init();
    end
  endtask

  task automatic send_beat(logic act, logic [7:0] v, int gap);
    if (gap > 0) begin
      valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    valid     <= 1'b1;
    action    <= act;
    data_byte <= v;
    do @(posedge clk); while (!ready);
    hash_beat(act, v);
    items_sent++;
  endtask

  task automatic send_message(int len, int max_gap);
    for (int i = 0; i < len; i++)
      send_beat(1'b0, 8'($urandom), $urandom_range(0, max_gap));
    send_beat(1'b1, 8'($urandom), $urandom_range(0, max_gap));
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic wait_drained();
    valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // result side: random stall per beat, plus an optional long hold-off
  initial begin
    int stall;
    digest_beat_t exp_beat;
    @(negedge rst);
    @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall > 0 || hold_off) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected beat", digest_word, '0);
      end else begin
        exp_beat = digest_q.pop_front();
        if (digest_word !== exp_beat.word)
          report_mismatch("digest_word", digest_word, exp_beat.word);
        if (word_index !== exp_beat.idx)
          report_mismatch("word_index", 32'(word_index), 32'(exp_beat.idx));
        if (last_word !== exp_beat.last)
          report_mismatch("last_word", 32'(last_word), 32'(exp_beat.last));
      end
    end
  end

  task automatic test_directed();
    send_beat(1'b1, 8'h00, 0);                 // empty message
    send_beat(1'b0, 8'h61, 0);                 // "abc"
    send_beat(1'b0, 8'h62, 0);
    send_beat(1'b0, 8'h63, 0);
    send_beat(1'b1, 8'hff, 0);
    send_beat(1'b0, 8'h00, 2);
    send_beat(1'b0, 8'hff, 0);
    send_beat(1'b0, 8'h80, 1);
    send_beat(1'b0, 8'h7f, 0);
    send_beat(1'b1, 8'h55, 3);
    send_beat(1'b1, 8'haa, 0);                 // back-to-back finishes, the second an empty message
  endtask

  // lengths around the pad boundary and full blocks
  task automatic test_boundaries();
    int lens[6] = '{55, 56, 57, 63, 64, 65};
    foreach (lens[i]) send_message(lens[i], (i % 2) ? 4 : 0);
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    send_message(2, 0);
    send_message(0, 0);
    send_message(5, 1);
  endtask

  task automatic test_pause_then_send();
    wait_drained();
    send_message(3, 0);
  endtask

  task automatic test_random();
    int len;
    while (items_sent < 480) begin
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 3);
        1: len = $urandom_range(50, 70);
        2: len = $urandom_range(0, 40);
        default: len = $urandom_range(100, 140);
      endcase
      // keep the total near the item budget
      if (len > 479 - items_sent) len = 479 - items_sent;
      // some messages with no sender gaps at all
      send_message(len, ($urandom_range(0, 3) == 0) ? 0 : 19);
    end
  endtask

  initial begin
    rst       <= 1'b1;
    valid     <= 1'b0;
    action    <= 1'b0;
    data_byte <= 8'h00;
    out_ready <= 1'b0;
    hash_init();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_boundaries();
    test_backpressure();
    test_pause_then_send();
    test_random();
    wait_drained();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
